// ----- rtl/fvpi_pkg.sv -----
// Shared types and constants for the filtered velocity PI loop.
`default_nettype none

package fvpi_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// field and state widths
	localparam int IN_W      = 16;
	localparam int MOVE_W    = 14;
	localparam int ERR_W     = 18;
	localparam int DRIVE_W   = 26;
	localparam int ST_W      = 40;
	localparam int INT_SUM_W = 42;

	// stream and config port widths
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int PROP_W  = 15;
	localparam int IGAIN_W = 10;
	localparam int LIMIT_W = 16;

	// shared multiplier: signed A times unsigned B, wide operands in two parts
	localparam int PART_W  = 20;
	localparam int MUL_A_W = 21;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = 54;

	// divide by 100: clamp, drop two bits, then multiply by ceil(2^35 / 25)
	localparam int                 QIN_W    = 30;
	localparam int                 RECIP_SH = 35;
	localparam logic [30:0]        RECIP_M  = 31'd1374389535;
	localparam logic [31:0]        DIV_SAT  = 32'd3355443200;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd2;

	localparam logic [PROP_W-1:0]  PROP_GAIN_RST   = 15'd7000;
	localparam logic [IGAIN_W-1:0] INTEG_GAIN_RST  = 10'd35;
	localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 16'd8000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
		ST_I0, ST_I1,
		ST_P0, ST_P1, ST_P2,
		ST_D0, ST_D1, ST_D2, ST_D3,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SHADD
	} acc_op_t;

endpackage

`default_nettype wire

// ----- rtl/filtered_velocity_pi_loop.sv -----
// Speed-loop PI controller with low-pass filtered error and clamped integral.
//
// Usage:
//   s_* : one transaction per control tick carrying both encoder readings, the
//         move command and the motor-off flag. s_tready is high only while the
//         loop is idle.
//   m_* : one transaction per tick carrying the saturated speed drive. The
//         result sits in an output register until taken.
//   cfg_* : single-cycle register writes (0 prop gain, 1 integral gain,
//         2 integral limit); write only between ticks. Index 3 is ignored.
// Timing: a tick runs through a 15-step sequencer around one shared
//   21x33 multiplier and its accumulator; the result is loaded as the
//   sequencer leaves its last step, and a new tick is taken only from the idle
//   step after that, so no tick is accepted while the last one is in progress.
// Stall: if the previous result has not been taken, the sequencer waits in its
//   last step, holding the new result and the integral clear.
// Reset: gains and limit return to their defaults, filter and integral state
//   clear to zero, output empty. No clearing pass is needed.
`default_nettype none

module filtered_velocity_pi_loop #(
	parameter int FRAC_BITS = fvpi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: left_count[15:0], right_count[31:16], move_command[45:32],
	//          motor_off[46], zero[47]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fvpi_pkg::S_TDATA_W-1:0]    s_tdata,
	// m_tdata: speed_drive[25:0], zero[31:26]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fvpi_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [fvpi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fvpi_pkg::CFG_W-1:0]        cfg_data
);
	import fvpi_pkg::*;

	// accumulator must hold filtered*C84 (40+FRAC bits) and the reciprocal product
	localparam int ACC_W = (FRAC_BITS + 42 > 62) ? FRAC_BITS + 42 : 62;

	// filter coefficients 0.84 and 0.16, rounded, summing to exactly one
	localparam logic [FRAC_BITS-1:0] COEF_OLD =
		FRAC_BITS'(((64'd84 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [FRAC_BITS-1:0] COEF_NEW =
		FRAC_BITS'((64'd1 << FRAC_BITS) - 64'(COEF_OLD));

	localparam logic signed [ST_W-1:0] S40_MAX = {1'b0, {(ST_W-1){1'b1}}};
	localparam logic signed [ST_W-1:0] S40_MIN = {1'b1, {(ST_W-1){1'b0}}};
	localparam logic [DRIVE_W-1:0]     S26_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
	localparam logic [ST_W:0]          BND_MAX = (ST_W+1)'(S40_MAX);
	localparam logic [ACC_W-1:0]       Q_MAX   = ACC_W'(64'd1 << (DRIVE_W-1));

	// configuration
	logic [PROP_W-1:0]  prop_gain_q;
	logic [IGAIN_W-1:0] integ_gain_q;
	logic [LIMIT_W-1:0] integ_limit_q;

	// sequencer
	state_t state_q, state_d;
	logic   out_free;

	// latched tick inputs
	logic signed [ERR_W-1:0]  err_q;
	logic signed [MOVE_W-1:0] move_q;
	logic                     off_q;
	logic signed [ERR_W-1:0]  err_in;

	// loop state
	logic signed [ST_W-1:0] filt_q;
	logic signed [ST_W-1:0] integ_q;

	// intermediates
	logic signed [INT_SUM_W-1:0] int_sum_q;
	logic signed [INT_SUM_W-1:0] int_sum_d;
	logic signed [INT_SUM_W-1:0] bound_pos;
	logic signed [INT_SUM_W-1:0] bound_neg;
	logic        [ST_W:0]        bound_raw;
	logic        [ST_W:0]        bound_lim;
	logic signed [ST_W-1:0]      integ_clamp;
	logic signed [ST_W-1:0]      filt_sat;
	logic                        acc_fits;
	logic        [QIN_W-1:0]     b_q;
	logic                        sum_neg_q;
	logic        [ACC_W-1:0]     mag;
	logic        [ACC_W-1:0]     mag_sh;
	logic        [31:0]          a_lim;
	logic        [DRIVE_W-1:0]   quot;
	logic        [DRIVE_W-1:0]   drive;
	logic        [DRIVE_W-1:0]   drive_q;
	logic                        m_tvalid_q;

	// shared multiplier and accumulator
	logic signed [MUL_A_W-1:0] mul_a;
	logic        [MUL_B_W-1:0] mul_b;
	acc_op_t                   acc_op;
	logic                      acc_hi;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  p_s1;
	acc_op_t                   acc_op_s1;
	logic                      hi_s1;
	logic signed [ACC_W-1:0]   p_ext;
	logic signed [ACC_W-1:0]   p_sh;
	logic signed [ACC_W-1:0]   acc_q;

	//--------------------------------------------------------------------
	// Configuration registers; value bits above a register's width dropped
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			integ_limit_q <= INTEG_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data[PROP_W-1:0];
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data[IGAIN_W-1:0];
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// Sequencer: next state
	//--------------------------------------------------------------------
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_F0;
			ST_F0:   state_d = ST_F1;
			ST_F1:   state_d = ST_F2;
			ST_F2:   state_d = ST_F3;
			ST_F3:   state_d = ST_F4;
			ST_F4:   state_d = ST_I0;
			ST_I0:   state_d = ST_I1;
			ST_I1:   state_d = ST_P0;
			ST_P0:   state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = ST_D0;
			ST_D0:   state_d = ST_D1;
			ST_D1:   state_d = ST_D2;
			ST_D2:   state_d = ST_D3;
			ST_D3:   state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	//--------------------------------------------------------------------
	// Sequencer: multiplier operands and accumulator command per step.
	// Wide values go in as low part (zero-extended) then high part (shifted).
	//--------------------------------------------------------------------
	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		acc_op   = ACC_NONE;
		acc_hi   = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			// filtered * C84
			ST_F0: begin
				mul_a  = {1'b0, filt_q[PART_W-1:0]};
				mul_b  = MUL_B_W'(COEF_OLD);
				acc_op = ACC_LOAD;
			end
			ST_F1: begin
				mul_a  = MUL_A_W'($signed(filt_q[ST_W-1:PART_W]));
				mul_b  = MUL_B_W'(COEF_OLD);
				acc_op = ACC_ADD;
				acc_hi = 1'b1;
			end
			// floor shift, then + error * C16
			ST_F2: begin
				mul_a  = MUL_A_W'(err_q);
				mul_b  = MUL_B_W'(COEF_NEW);
				acc_op = ACC_SHADD;
			end
			// filtered * prop_gain
			ST_I0: begin
				mul_a  = {1'b0, filt_q[PART_W-1:0]};
				mul_b  = MUL_B_W'(prop_gain_q);
				acc_op = ACC_LOAD;
			end
			ST_I1: begin
				mul_a  = MUL_A_W'($signed(filt_q[ST_W-1:PART_W]));
				mul_b  = MUL_B_W'(prop_gain_q);
				acc_op = ACC_ADD;
				acc_hi = 1'b1;
			end
			// + integral * integ_gain
			ST_P0: begin
				mul_a  = {1'b0, integ_q[PART_W-1:0]};
				mul_b  = MUL_B_W'(integ_gain_q);
				acc_op = ACC_ADD;
			end
			ST_P1: begin
				mul_a  = MUL_A_W'($signed(integ_q[ST_W-1:PART_W]));
				mul_b  = MUL_B_W'(integ_gain_q);
				acc_op = ACC_ADD;
				acc_hi = 1'b1;
			end
			// clamped magnitude / 4 times reciprocal of 25
			ST_D1: begin
				mul_a  = {1'b0, b_q[PART_W-1:0]};
				mul_b  = MUL_B_W'(RECIP_M);
				acc_op = ACC_LOAD;
			end
			ST_D2: begin
				mul_a  = MUL_A_W'(b_q[QIN_W-1:PART_W]);
				mul_b  = MUL_B_W'(RECIP_M);
				acc_op = ACC_ADD;
				acc_hi = 1'b1;
			end
			default: ;
		endcase
	end

	//--------------------------------------------------------------------
	// Shared multiplier, registered product, accumulator in the next cycle
	//--------------------------------------------------------------------
	assign prod = mul_a * $signed({1'b0, mul_b});

	always_ff @(posedge clk) begin
		p_s1  <= prod;
		hi_s1 <= acc_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_op_s1 <= ACC_NONE;
		end else begin
			acc_op_s1 <= acc_op;
		end
	end

	assign p_ext = ACC_W'(p_s1);
	assign p_sh  = hi_s1 ? (p_ext <<< PART_W) : p_ext;

	always_ff @(posedge clk) begin
		case (acc_op_s1)
			ACC_LOAD:  acc_q <= p_sh;
			ACC_ADD:   acc_q <= acc_q + p_sh;
			ACC_SHADD: acc_q <= (acc_q >>> FRAC_BITS) + p_sh;
			default: ;
		endcase
	end

	//--------------------------------------------------------------------
	// Side datapath
	//--------------------------------------------------------------------
	assign err_in = -(ERR_W'($signed(s_tdata[IN_W-1:0]))
		+ ERR_W'($signed(s_tdata[2*IN_W-1:IN_W])));

	// filter saturation to 40-bit signed
	assign acc_fits = (&acc_q[ACC_W-1:ST_W-1]) || !(|acc_q[ACC_W-1:ST_W-1]);
	assign filt_sat = acc_fits ? acc_q[ST_W-1:0] : (acc_q[ACC_W-1] ? S40_MIN : S40_MAX);

	// integral update and symmetric clamp; bound capped to the 40-bit range
	assign int_sum_d = INT_SUM_W'(filt_q) + INT_SUM_W'(integ_q)
		+ (INT_SUM_W'(move_q) <<< FRAC_BITS);
	assign bound_raw = (ST_W+1)'(integ_limit_q) << FRAC_BITS;
	assign bound_lim = (bound_raw > BND_MAX) ? BND_MAX : bound_raw;
	assign bound_pos = $signed(INT_SUM_W'(bound_lim));
	assign bound_neg = -bound_pos;
	assign integ_clamp = (int_sum_q > bound_pos) ? bound_pos[ST_W-1:0] :
		(int_sum_q < bound_neg) ? bound_neg[ST_W-1:0] : int_sum_q[ST_W-1:0];

	// |sum| / 2^FRAC, clamped at the value that already saturates the drive
	assign mag    = acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
	assign mag_sh = mag >> FRAC_BITS;
	assign a_lim  = (mag_sh >= ACC_W'(DIV_SAT)) ? DIV_SAT : mag_sh[31:0];

	// quotient is at most 2^25; sign follows the negated sum
	assign quot  = acc_q[RECIP_SH +: DRIVE_W];
	assign drive = sum_neg_q ? (quot[DRIVE_W-1] ? S26_MAX : quot) : (DRIVE_W'(0) - quot);

	// tick inputs and intermediates
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					err_q  <= err_in;
					move_q <= $signed(s_tdata[2*IN_W+MOVE_W-1:2*IN_W]);
					off_q  <= s_tdata[2*IN_W+MOVE_W];
				end
			end
			ST_I0: int_sum_q <= int_sum_d;
			ST_D0: begin
				b_q       <= a_lim[31:2];
				sum_neg_q <= acc_q[ACC_W-1];
			end
			ST_OUT: if (out_free) drive_q <= drive;
			default: ;
		endcase
	end

	// loop state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q     <= '0;
			integ_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_F4: filt_q <= filt_sat;
				ST_I1: integ_q <= integ_clamp;
				ST_OUT: if (out_free && off_q) integ_q <= '0;
				default: ;
			endcase
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(drive_q);

`ifndef SYNTHESIS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_F0))
		else $error("accepted tick did not start the sequence");

	a_off_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && off_q) |=> (integ_q == '0))
		else $error("integral not cleared with motor off");

	a_int_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P0) |->
		(INT_SUM_W'(integ_q) <= bound_pos && INT_SUM_W'(integ_q) >= bound_neg))
		else $error("integral outside its clamp");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (!acc_q[ACC_W-1] && ($unsigned(acc_q) >> RECIP_SH) <= Q_MAX))
		else $error("divide result above saturation point");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output step");
`endif

endmodule

`default_nettype wire
